@@ rtl/core/scc_pkg.sv @@
// Shared types, constants and helper functions of the sphere coordinate converter.
// Depends on nothing; the top level and scc_cell import it.
package scc_pkg;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] KINV_Q32 = 64'h0000_0000_9B74_EDA8;
   localparam logic [63:0] DEG2RAD_Q64 = (PI_Q60 / 64'd45) * 64'd4;
   localparam logic [191:0] RAD2DEG_WIDE = (192'd180 << 117) / {128'd0, PI_Q60};
   localparam logic [63:0] RAD2DEG_K = RAD2DEG_WIDE[63:0];
   localparam logic signed [63:0] PI_Q59 = signed'((PI_Q60 + 64'd1) >> 1);

   localparam logic signed [63:0] DEG90 = 64'sd377487360;
   localparam logic signed [63:0] DEG180 = 64'sd754974720;
   localparam logic signed [63:0] DEG270 = 64'sd1132462080;
   localparam logic signed [63:0] DEG360 = 64'sd1509949440;
   localparam logic signed [63:0] POS_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] POS_MIN = -64'sd140737488355328;
   localparam logic [46:0] RADIUS_RESET = 47'd417529856000;

   localparam int GUARD = 12;
   localparam int MUL_LAT = 5;   // stages of scc_mulsh

   typedef struct packed {
      logic mode;
      logic zero;
      logic xz_nz;
      logic neg1;
      logic neg2;
      logic signed [63:0] s0;
      logic signed [63:0] s1;
      logic signed [63:0] s2;
      logic signed [63:0] s3;
   } side_type;

   // atan(2^-idx) in radians, 59 fraction bits, from the truncated series at 62 bits
   function automatic logic [63:0] atan_step(input int unsigned idx);
      logic [63:0] q;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      int unsigned k;
      int unsigned d;
      int b;
      q = 64'd0;
      if (idx == 0) begin
         q = PI_Q60;
      end else begin
         for (k = 0; idx * (2 * k + 1) <= 62; k++) begin
            d = 2 * k + 1;
            num = 64'd1 << (62 - idx * d);
            rem = 64'd0;
            quo = 64'd0;
            for (b = 63; b >= 0; b--) begin
               rem = {rem[62:0], num[b]};
               quo = {quo[62:0], 1'b0};
               if (rem >= 64'(d)) begin
                  rem = rem - 64'(d);
                  quo[0] = 1'b1;
               end
            end
            q = k[0] ? q - quo : q + quo;
         end
      end
      return (q + 64'd4) >> 3;
   endfunction

   // one correction step; valid for angles in [-540, 540) degrees
   function automatic logic signed [63:0] wrap180(input logic signed [63:0] a);
      logic signed [63:0] r;
      r = a;
      if (a >= DEG180) begin
         r = a - DEG360;
      end else if (a < -DEG180) begin
         r = a + DEG360;
      end
      return r;
   endfunction

   function automatic logic signed [47:0] to_pos(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v + 64'sd2048) >>> GUARD;
      if (r > POS_MAX) begin
         r = POS_MAX;
      end else if (r < POS_MIN) begin
         r = POS_MIN;
      end
      return r[47:0];
   endfunction

endpackage

@@ rtl/core/sphere_coord_cartesian_convert.sv @@
// Sphere coordinate converter, top level: front end, two CORDIC cell rows, multipliers.
// Depends on scc_pkg, scc_delay, scc_mulsh, scc_chain (and through it scc_cell).
//
// Usage
//  - req_ channel: one item per cycle, accepted when req_valid is high and req_stall is
//    low. req_mode 0 turns latitude/longitude/altitude into a point, 1 turns a point
//    into latitude, longitude and radial length.
//  - rsp_ channel: exactly one result item per accepted item, in order.
//  - csr_: write csr_wr_en with csr_wr_data to load the sphere radius; only while idle.
//  - Pipeline: one prep stage, three ranks of five-stage constant multipliers, two
//    rows of CORDIC cells of CORDIC_ITERATIONS stages each, two fix-up stages and
//    the output register.
//  - Throughput: one item per cycle unless stalled; rows, multipliers fully pipelined.
//  - Stall: while a result waits in the output register and rsp_stall is high, the
//    whole pipeline holds and req_stall is high; items in flight keep their places.
//  - Reset: clears all valid bits and loads the default radius; no result pending.
//  - The inverse radial length is the full vector length, not length minus radius.
module sphere_coord_cartesian_convert #(
   parameter int CORDIC_ITERATIONS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic signed [29:0] req_in_latitude,
   input  logic signed [30:0] req_in_longitude,
   input  logic signed [47:0] req_in_altitude,
   input  logic signed [47:0] req_in_x,
   input  logic signed [47:0] req_in_y,
   input  logic signed [47:0] req_in_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_out_x,
   output logic signed [47:0] rsp_out_y,
   output logic signed [47:0] rsp_out_z,
   output logic signed [29:0] rsp_out_latitude,
   output logic signed [30:0] rsp_out_longitude,
   output logic [46:0]        rsp_out_radial_length,
   output logic               rsp_zero_vector,
   input  logic               csr_wr_en,
   input  logic [46:0]        csr_wr_data
);
   import scc_pkg::*;

   localparam int SIDE_W = $bits(side_type);

   logic adv;   // whole pipeline moves one step

   logic [46:0] radius_ff;

   // prep stage
   logic signed [63:0] la, lo, al, a1, a2, a1f, a2f, vx, vy, vz, vrad;
   logic               neg1, neg2;
   side_type           p0_side_in, p0_side_ff;
   logic signed [63:0] p0_ma_in, p0_mb_in, p0_mc_in;
   logic signed [63:0] p0_ma_ff, p0_mb_ff, p0_mc_ff;
   logic               p0_vld_ff;

   // first multiplier set and first cell row
   logic signed [63:0] m1a, m1b, m1c;
   logic               d1_vld;
   logic [SIDE_W-1:0]  d1_side;
   side_type           d1_s, c1in_s;
   logic signed [63:0] c1in_x, c1in_y, c1in_z;
   logic               c1_vld, c1_vec;
   logic signed [63:0] c1_x, c1_y, c1_z;
   logic [SIDE_W-1:0]  c1_side;
   side_type           c1_s;

   // fix-up after first row
   side_type           f1_side_in, f1_side_ff;
   logic signed [63:0] f1_val_in, f1_val_ff;
   logic               f1_vld_ff;

   // second multiplier and cell row
   logic signed [63:0] m2a;
   logic               d2_vld;
   logic [SIDE_W-1:0]  d2_side;
   side_type           d2_s;
   logic signed [63:0] c2in_x, c2in_y, c2in_z;
   logic               c2_vld, c2_vec;
   logic signed [63:0] c2_x, c2_y, c2_z;
   logic [SIDE_W-1:0]  c2_side;
   side_type           c2_s;

   // fix-up after second row
   side_type           f2_side_in, f2_side_ff;
   logic signed [63:0] f2_ma_in, f2_mb_in, f2_mc_in;
   logic signed [63:0] f2_ma_ff, f2_mb_ff, f2_mc_ff;
   logic               f2_vld_ff;

   // last multiplier set and output register
   logic signed [63:0] m3a, m3b, m3c;
   logic               d3_vld;
   logic [SIDE_W-1:0]  d3_side;
   side_type           d3_s;
   logic signed [63:0] lat_w, lon_w, len_u;
   logic [63:0]        len_q;
   logic               rsp_valid_ff;
   logic signed [47:0] out_x_in, out_y_in, out_z_in, out_x_ff, out_y_ff, out_z_ff;
   logic signed [29:0] out_lat_in, out_lat_ff;
   logic signed [30:0] out_lon_in, out_lon_ff;
   logic [46:0]        out_len_in, out_len_ff;
   logic               zero_in, zero_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // prep: angle wrap and fold, guard bits, half-plane reflection
   always_comb begin
      la = 64'(req_in_latitude);
      lo = 64'(req_in_longitude);
      al = 64'(req_in_altitude);
      vrad = (signed'({17'd0, radius_ff}) + al) <<< GUARD;
      a1 = wrap180(DEG90 - la);
      a2 = wrap180(-(lo + DEG90));
      // fold into [-90, 90]; the result is negated at the end of the row
      neg1 = 1'b0;
      a1f = a1;
      if (a1 > DEG90) begin
         a1f = a1 - DEG180;
         neg1 = 1'b1;
      end else if (a1 < -DEG90) begin
         a1f = a1 + DEG180;
         neg1 = 1'b1;
      end
      neg2 = 1'b0;
      a2f = a2;
      if (a2 > DEG90) begin
         a2f = a2 - DEG180;
         neg2 = 1'b1;
      end else if (a2 < -DEG90) begin
         a2f = a2 + DEG180;
         neg2 = 1'b1;
      end
      vx = 64'(req_in_x) <<< GUARD;
      vy = 64'(req_in_y) <<< GUARD;
      vz = 64'(req_in_z) <<< GUARD;

      p0_side_in = '0;
      p0_side_in.mode = req_mode;
      p0_side_in.neg1 = neg1;
      p0_side_in.neg2 = neg2;
      p0_side_in.zero = (req_in_x == 48'sd0) && (req_in_y == 48'sd0) && (req_in_z == 48'sd0);
      p0_side_in.xz_nz = (req_in_x != 48'sd0) || (req_in_z != 48'sd0);
      p0_side_in.s0 = vx;
      p0_side_in.s1 = vz;
      p0_side_in.s2 = vy;
      p0_side_in.s3 = 64'sd0;
      // left half plane: reflect through the origin, start from +-pi
      if (vx < 0) begin
         p0_side_in.s0 = -vx;
         p0_side_in.s1 = -vz;
         p0_side_in.s3 = (vz >= 0) ? PI_Q59 : -PI_Q59;
      end
      p0_ma_in = vrad;
      p0_mb_in = a1f;
      p0_mc_in = a2f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
      end else if (adv) begin
         p0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_side_ff <= p0_side_in;
         p0_ma_ff <= p0_ma_in;
         p0_mb_ff <= p0_mb_in;
         p0_mc_ff <= p0_mc_in;
      end
   end

   // ---------------- gain removal on the radius, degrees to radians for both angles
   scc_mulsh #(.SHIFT(32), .K(KINV_Q32)) u_m1a (
      .clock(clock), .en(adv), .a(p0_ma_ff), .p(m1a));
   scc_mulsh #(.SHIFT(27), .K(DEG2RAD_Q64)) u_m1b (
      .clock(clock), .en(adv), .a(p0_mb_ff), .p(m1b));
   scc_mulsh #(.SHIFT(27), .K(DEG2RAD_Q64)) u_m1c (
      .clock(clock), .en(adv), .a(p0_mc_ff), .p(m1c));
   scc_delay #(.W(SIDE_W), .DEPTH(MUL_LAT)) u_d1 (
      .clock(clock), .reset(reset), .en(adv),
      .up_vld(p0_vld_ff), .up_d(p0_side_ff), .dn_vld(d1_vld), .dn_d(d1_side));

   always_comb begin
      d1_s = side_type'(d1_side);
      c1in_s = d1_s;
      if (!d1_s.mode) begin
         // rotate (r, 0) by the colatitude; keep the longitude angle for row two
         c1in_x = m1a;
         c1in_y = 64'sd0;
         c1in_z = m1b;
         c1in_s.s0 = m1c;
      end else begin
         // vector (x, z) onto the x axis
         c1in_x = d1_s.s0;
         c1in_y = d1_s.s1;
         c1in_z = 64'sd0;
      end
   end

   scc_chain #(.N(CORDIC_ITERATIONS), .SIDE_W(SIDE_W)) u_row1 (
      .clock(clock), .reset(reset), .en(adv),
      .up_vld(d1_vld), .up_vec(d1_s.mode), .up_x(c1in_x), .up_y(c1in_y), .up_z(c1in_z),
      .up_side(c1in_s),
      .dn_vld(c1_vld), .dn_vec(c1_vec), .dn_x(c1_x), .dn_y(c1_y), .dn_z(c1_z),
      .dn_side(c1_side));

   // ---------------- unfold row one
   always_comb begin
      c1_s = side_type'(c1_side);
      f1_side_in = c1_s;
      if (!c1_vec) begin
         f1_side_in.s1 = c1_s.neg1 ? -c1_x : c1_x;   // y of the point, r*cos(colat)
         f1_val_in = c1_s.neg1 ? -c1_y : c1_y;        // r*sin(colat)
      end else begin
         f1_side_in.s3 = c1_s.xz_nz ? c1_s.s3 + c1_z : 64'sd0;   // azimuth in radians
         f1_val_in = c1_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= c1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_side_ff <= f1_side_in;
         f1_val_ff <= f1_val_in;
      end
   end

   scc_mulsh #(.SHIFT(32), .K(KINV_Q32)) u_m2 (
      .clock(clock), .en(adv), .a(f1_val_ff), .p(m2a));
   scc_delay #(.W(SIDE_W), .DEPTH(MUL_LAT)) u_d2 (
      .clock(clock), .reset(reset), .en(adv),
      .up_vld(f1_vld_ff), .up_d(f1_side_ff), .dn_vld(d2_vld), .dn_d(d2_side));

   always_comb begin
      d2_s = side_type'(d2_side);
      c2in_x = m2a;
      if (!d2_s.mode) begin
         c2in_y = 64'sd0;
         c2in_z = d2_s.s0;
      end else begin
         c2in_y = d2_s.s2;
         c2in_z = 64'sd0;
      end
   end

   scc_chain #(.N(CORDIC_ITERATIONS), .SIDE_W(SIDE_W)) u_row2 (
      .clock(clock), .reset(reset), .en(adv),
      .up_vld(d2_vld), .up_vec(d2_s.mode), .up_x(c2in_x), .up_y(c2in_y), .up_z(c2in_z),
      .up_side(d2_s),
      .dn_vld(c2_vld), .dn_vec(c2_vec), .dn_x(c2_x), .dn_y(c2_y), .dn_z(c2_z),
      .dn_side(c2_side));

   // ---------------- unfold row two, feed the last multipliers
   always_comb begin
      c2_s = side_type'(c2_side);
      f2_side_in = c2_s;
      f2_ma_in = c2_x;
      f2_mb_in = c2_z;
      f2_mc_in = c2_s.s3;
      if (!c2_vec) begin
         f2_side_in.s0 = c2_s.neg2 ? -c2_x : c2_x;
         f2_side_in.s2 = c2_s.neg2 ? -c2_y : c2_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f2_vld_ff <= c2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_side_ff <= f2_side_in;
         f2_ma_ff <= f2_ma_in;
         f2_mb_ff <= f2_mb_in;
         f2_mc_ff <= f2_mc_in;
      end
   end

   scc_mulsh #(.SHIFT(32), .K(KINV_Q32)) u_m3a (
      .clock(clock), .en(adv), .a(f2_ma_ff), .p(m3a));
   scc_mulsh #(.SHIFT(94), .K(RAD2DEG_K)) u_m3b (
      .clock(clock), .en(adv), .a(f2_mb_ff), .p(m3b));
   scc_mulsh #(.SHIFT(94), .K(RAD2DEG_K)) u_m3c (
      .clock(clock), .en(adv), .a(f2_mc_ff), .p(m3c));
   scc_delay #(.W(SIDE_W), .DEPTH(MUL_LAT)) u_d3 (
      .clock(clock), .reset(reset), .en(adv),
      .up_vld(f2_vld_ff), .up_d(f2_side_ff), .dn_vld(d3_vld), .dn_d(d3_side));

   // ---------------- result formatting
   always_comb begin
      d3_s = side_type'(d3_side);
      lat_w = m3b;
      if (lat_w > DEG90) begin
         lat_w = DEG90;
      end else if (lat_w < -DEG90) begin
         lat_w = -DEG90;
      end
      lon_w = wrap180(DEG270 - m3c);
      len_u = m3a + 64'sd2048;
      len_q = unsigned'(len_u) >> GUARD;
      out_x_in = '0;
      out_y_in = '0;
      out_z_in = '0;
      out_lat_in = '0;
      out_lon_in = '0;
      out_len_in = '0;
      zero_in = 1'b0;
      if (!d3_s.mode) begin
         out_x_in = to_pos(d3_s.s0);
         out_y_in = to_pos(d3_s.s1);
         out_z_in = to_pos(d3_s.s2);
      end else if (d3_s.zero) begin
         zero_in = 1'b1;
      end else begin
         out_lat_in = lat_w[29:0];
         out_lon_in = lon_w[30:0];
         out_len_in = (len_q > unsigned'(POS_MAX)) ? {47{1'b1}} : len_q[46:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
         out_lat_ff <= out_lat_in;
         out_lon_ff <= out_lon_in;
         out_len_ff <= out_len_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_z = out_z_ff;
   assign rsp_out_latitude = out_lat_ff;
   assign rsp_out_longitude = out_lon_ff;
   assign rsp_out_radial_length = out_len_ff;
   assign rsp_zero_vector = zero_ff;

`ifndef ASSERT_OFF
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_latitude <= 30'sd377487360) &&
                    (rsp_out_latitude >= -30'sd377487360))
      else $error("latitude outside [-90, 90]");

   a_lon_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_longitude < 31'sd754974720) &&
                    (rsp_out_longitude >= -31'sd754974720))
      else $error("longitude outside [-180, 180)");

   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> (rsp_out_radial_length == 47'd0) &&
         (rsp_out_latitude == 30'sd0) && (rsp_out_longitude == 31'sd0) &&
         (rsp_out_x == 48'sd0) && (rsp_out_y == 48'sd0) && (rsp_out_z == 48'sd0))
      else $error("zero vector item with nonzero fields");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(p0_vld_ff) && $stable(d3_vld))
      else $error("pipeline moved while output stalled");
`endif
endmodule

@@ rtl/core/scc_delay.sv @@
// Sideband delay line that runs beside the multipliers.
// Depends on nothing.
module scc_delay #(
   parameter int W = 8,
   parameter int DEPTH = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         up_vld,
   input  logic [W-1:0] up_d,
   output logic         dn_vld,
   output logic [W-1:0] dn_d
);
   logic         vld_ff [DEPTH];
   logic [W-1:0] d_ff   [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= up_vld;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= up_d;
         for (int i = 1; i < DEPTH; i++) d_ff[i] <= d_ff[i-1];
      end
   end

   assign dn_vld = vld_ff[DEPTH-1];
   assign dn_d = d_ff[DEPTH-1];
endmodule

@@ rtl/core/scc_mulsh.sv @@
// Pipelined signed multiply by a constant with round half away from zero and shift.
// Five stages: magnitude, 32x32 partial products, sum, round/shift/saturate, sign.
module scc_mulsh #(
   parameter int SHIFT = 32,
   parameter logic [63:0] K = 64'd1
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] a,
   output logic signed [63:0] p
);
   localparam logic [128:0] HALF = 129'd1 << (SHIFT - 1);

   logic [63:0]  mag_ff;
   logic         sgn1_ff, sgn2_ff, sgn3_ff, sgn4_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] sum_ff;
   logic [62:0]  res_ff;
   logic signed [63:0] p_ff;
   logic [128:0] t_in;
   logic [128:0] q_in;
   logic [62:0]  res_in;

   always_comb begin
      t_in = {1'b0, sum_ff} + HALF;
      q_in = t_in >> SHIFT;
      res_in = (|q_in[128:63]) ? {63{1'b1}} : q_in[62:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= a[63] ? unsigned'(-a) : unsigned'(a);
         sgn1_ff <= a[63];
         p00_ff <= 64'(mag_ff[31:0]) * 64'(K[31:0]);
         p01_ff <= 64'(mag_ff[31:0]) * 64'(K[63:32]);
         p10_ff <= 64'(mag_ff[63:32]) * 64'(K[31:0]);
         p11_ff <= 64'(mag_ff[63:32]) * 64'(K[63:32]);
         sgn2_ff <= sgn1_ff;
         sum_ff <= {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
                   + {p11_ff, 64'd0};
         sgn3_ff <= sgn2_ff;
         res_ff <= res_in;
         sgn4_ff <= sgn3_ff;
         p_ff <= sgn4_ff ? -signed'({1'b0, res_ff}) : signed'({1'b0, res_ff});
      end
   end

   assign p = p_ff;
endmodule

@@ rtl/core/scc_cell.sv @@
// One CORDIC micro-rotation with a fixed shift, rotation or vectoring per item.
// Depends on scc_pkg for the step angle.
module scc_cell #(
   parameter int IDX = 0,
   parameter int SIDE_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               up_vld,
   input  logic               up_vec,
   input  logic signed [63:0] up_x,
   input  logic signed [63:0] up_y,
   input  logic signed [63:0] up_z,
   input  logic [SIDE_W-1:0]  up_side,
   output logic               dn_vld,
   output logic               dn_vec,
   output logic signed [63:0] dn_x,
   output logic signed [63:0] dn_y,
   output logic signed [63:0] dn_z,
   output logic [SIDE_W-1:0]  dn_side
);
   import scc_pkg::*;

   localparam logic signed [63:0] ATAN = signed'(atan_step(IDX));

   logic               vld_ff, vec_ff;
   logic signed [63:0] x_ff, y_ff, z_ff;
   logic signed [63:0] x_in, y_in, z_in;
   logic [SIDE_W-1:0]  side_ff;
   logic               ccw;

   // vectoring turns toward y = 0, rotation toward z = 0
   always_comb begin
      ccw = up_vec ? up_y[63] : !up_z[63];
      if (ccw) begin
         x_in = up_x - (up_y >>> IDX);
         y_in = up_y + (up_x >>> IDX);
         z_in = up_z - ATAN;
      end else begin
         x_in = up_x + (up_y >>> IDX);
         y_in = up_y - (up_x >>> IDX);
         z_in = up_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= up_vec;
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         side_ff <= up_side;
      end
   end

   assign dn_vld = vld_ff;
   assign dn_vec = vec_ff;
   assign dn_x = x_ff;
   assign dn_y = y_ff;
   assign dn_z = z_ff;
   assign dn_side = side_ff;
endmodule

@@ rtl/core/scc_chain.sv @@
// Row of CORDIC cells, shift index 0 to N-1, each cell registered.
// Depends on scc_cell.
module scc_chain #(
   parameter int N = 32,
   parameter int SIDE_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               up_vld,
   input  logic               up_vec,
   input  logic signed [63:0] up_x,
   input  logic signed [63:0] up_y,
   input  logic signed [63:0] up_z,
   input  logic [SIDE_W-1:0]  up_side,
   output logic               dn_vld,
   output logic               dn_vec,
   output logic signed [63:0] dn_x,
   output logic signed [63:0] dn_y,
   output logic signed [63:0] dn_z,
   output logic [SIDE_W-1:0]  dn_side
);
   logic               vld [N+1];
   logic               vec [N+1];
   logic signed [63:0] xs  [N+1];
   logic signed [63:0] ys  [N+1];
   logic signed [63:0] zs  [N+1];
   logic [SIDE_W-1:0]  sd  [N+1];

   assign vld[0] = up_vld;
   assign vec[0] = up_vec;
   assign xs[0] = up_x;
   assign ys[0] = up_y;
   assign zs[0] = up_z;
   assign sd[0] = up_side;

   for (genvar i = 0; i < N; i++) begin : g_cell
      scc_cell #(.IDX(i), .SIDE_W(SIDE_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .up_vld(vld[i]), .up_vec(vec[i]), .up_x(xs[i]), .up_y(ys[i]), .up_z(zs[i]),
         .up_side(sd[i]),
         .dn_vld(vld[i+1]), .dn_vec(vec[i+1]), .dn_x(xs[i+1]), .dn_y(ys[i+1]),
         .dn_z(zs[i+1]), .dn_side(sd[i+1])
      );
   end

   assign dn_vld = vld[N];
   assign dn_vec = vec[N];
   assign dn_x = xs[N];
   assign dn_y = ys[N];
   assign dn_z = zs[N];
   assign dn_side = sd[N];
endmodule

@@ tb/sphere_coord_cartesian_convert_tb.sv @@
// Testbench for sphere_coord_cartesian_convert: directed table and random items, predicted
// by an in-bench bit-exact CORDIC model. Depends only on the RTL of the block.
module sphere_coord_cartesian_convert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // ---------------------------------------------------------------- constants
   localparam bit MODE_FWD = 1'b0;   // lat/lon/alt -> point
   localparam bit MODE_INV = 1'b1;   // point -> lat/lon/length
   localparam int N_ITER = 32;
   localparam int GUARD_SH = 12;
   localparam int LATENCY = 2 * N_ITER + 19;
   localparam int SETTLE = LATENCY + 40;
   localparam int ITEMS_PER_PHASE = 380;
   localparam int N_PHASES = 5;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int QUIET_FROM = 3000;   // window with no idling on either side
   localparam int QUIET_TO = 5000;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] KINV_Q32 = 64'h0000_0000_9B74_EDA8;
   localparam logic [63:0] DEG2RAD_Q64 = (PI_Q60 / 64'd45) * 64'd4;
   localparam logic [191:0] RAD2DEG_FULL = (192'd180 << 117) / {128'd0, PI_Q60};
   localparam logic [63:0] RAD2DEG_Q57 = RAD2DEG_FULL[63:0];
   localparam longint PI_Q59 = longint'((PI_Q60 + 64'd1) >> 1);

   localparam longint D90 = 64'sd377487360;
   localparam longint D180 = 64'sd754974720;
   localparam longint D270 = 64'sd1132462080;
   localparam longint D360 = 64'sd1509949440;
   localparam longint P_MAX = 64'sd140737488355327;
   localparam longint P_MIN = -64'sd140737488355328;
   localparam longint LON_MAX = D180 - 1;
   localparam longint R_DEFAULT = 64'sd417529856000;

   // ---------------------------------------------------------------- types
   typedef struct {
      bit mode;
      longint lat, lon, alt, x, y, z;
   } coord_item_t;

   typedef struct {
      logic signed [47:0] x, y, z;
      logic signed [29:0] lat;
      logic signed [30:0] lon;
      logic [46:0]        len;
      logic               zero;
   } coord_result_t;

   typedef struct {
      coord_item_t item;
      bit          typed;      // expected result is all zeros but the flag
      bit          zero_flag;
   } table_row_t;

   // ---------------------------------------------------------------- DUT signals
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = 1'b0;
   logic signed [29:0] req_in_latitude = '0;
   logic signed [30:0] req_in_longitude = '0;
   logic signed [47:0] req_in_altitude = '0;
   logic signed [47:0] req_in_x = '0;
   logic signed [47:0] req_in_y = '0;
   logic signed [47:0] req_in_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [47:0] rsp_out_x;
   logic signed [47:0] rsp_out_y;
   logic signed [47:0] rsp_out_z;
   logic signed [29:0] rsp_out_latitude;
   logic signed [30:0] rsp_out_longitude;
   logic [46:0]        rsp_out_radial_length;
   logic               rsp_zero_vector;
   logic               csr_wr_en = 1'b0;
   logic [46:0]        csr_wr_data = '0;

   sphere_coord_cartesian_convert u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_in_latitude       (req_in_latitude),
      .req_in_longitude      (req_in_longitude),
      .req_in_altitude       (req_in_altitude),
      .req_in_x              (req_in_x),
      .req_in_y              (req_in_y),
      .req_in_z              (req_in_z),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_x             (rsp_out_x),
      .rsp_out_y             (rsp_out_y),
      .rsp_out_z             (rsp_out_z),
      .rsp_out_latitude      (rsp_out_latitude),
      .rsp_out_longitude     (rsp_out_longitude),
      .rsp_out_radial_length (rsp_out_radial_length),
      .rsp_zero_vector       (rsp_zero_vector),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- state
   longint          radius_now = R_DEFAULT;   // mirror of the radius register
   longint          atan_q59 [0:N_ITER-1];
   coord_result_t   pending_results [$];
   int              fail_count = 0;
   longint          cycle_count = 0;

   // ---------------------------------------------------------------- predictor
   // round(a * k / 2^s), half away from zero, saturating at int64 max
   function automatic longint scale_round(input longint a, input logic [63:0] k, input int s);
      logic [63:0]  mag;
      logic [128:0] prod;
      logic [63:0]  res;
      mag = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
      prod = {65'd0, mag} * {65'd0, k};
      prod = prod + (129'd1 << (s - 1));
      prod = prod >> s;
      res = (prod[128:64] != 0) ? '1 : prod[63:0];
      if (res[63]) begin
         res = 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return (a < 0) ? -longint'(res) : longint'(res);
   endfunction

   function automatic longint wrap_deg(input longint a);
      longint r;
      r = (a + D180) % D360;
      if (r < 0) begin
         r += D360;
      end
      return r - D180;
   endfunction

   // rotate (v, 0) by a degrees (Q22, in [-180, 180))
   function automatic void cordic_rotate(input longint v, input longint a,
                                         output longint c, output longint s);
      bit     flip;
      longint px, py, ang, t;
      flip = 1'b0;
      if (a > D90) begin
         a -= D180;
         flip = 1'b1;
      end else if (a < -D90) begin
         a += D180;
         flip = 1'b1;
      end
      px = scale_round(v, KINV_Q32, 32);
      py = 0;
      ang = scale_round(a, DEG2RAD_Q64, 27);
      for (int i = 0; i < N_ITER; i++) begin
         if (ang >= 0) begin
            t = px - (py >>> i);
            py = py + (px >>> i);
            ang -= atan_q59[i];
         end else begin
            t = px + (py >>> i);
            py = py - (px >>> i);
            ang += atan_q59[i];
         end
         px = t;
      end
      c = flip ? -px : px;
      s = flip ? -py : py;
   endfunction

   // drive py to zero; returns the angle turned, radians Q59
   function automatic longint cordic_vector(inout longint px, inout longint py);
      longint ang, t;
      ang = 0;
      for (int i = 0; i < N_ITER; i++) begin
         if (py >= 0) begin
            t = px + (py >>> i);
            py = py - (px >>> i);
            ang += atan_q59[i];
         end else begin
            t = px - (py >>> i);
            py = py + (px >>> i);
            ang -= atan_q59[i];
         end
         px = t;
      end
      return ang;
   endfunction

   function automatic longint drop_guard(input longint v);
      longint r;
      r = (v + (64'sd1 <<< (GUARD_SH - 1))) >>> GUARD_SH;
      if (r > P_MAX) begin
         r = P_MAX;
      end else if (r < P_MIN) begin
         r = P_MIN;
      end
      return r;
   endfunction

   function automatic coord_result_t convert_item(input coord_item_t it);
      coord_result_t r;
      longint v, c, s, cx, sz;
      longint vx, vy, vz, phi, mag, rho, theta, lat, base;
      logic [63:0] len;
      r = '{default: '0};
      if (it.mode == MODE_FWD) begin
         v = (radius_now + it.alt) * (64'sd1 <<< GUARD_SH);
         cordic_rotate(v, wrap_deg(D90 - it.lat), c, s);
         cordic_rotate(s, wrap_deg(-(it.lon + D90)), cx, sz);
         r.x = 48'(drop_guard(cx));
         r.y = 48'(drop_guard(c));
         r.z = 48'(drop_guard(sz));
      end else if (it.x == 0 && it.y == 0 && it.z == 0) begin
         r.zero = 1'b1;
      end else begin
         vx = it.x <<< GUARD_SH;
         vy = it.y <<< GUARD_SH;
         vz = it.z <<< GUARD_SH;
         phi = 0;
         mag = 0;
         if (vx != 0 || vz != 0) begin
            base = 0;
            if (vx < 0) begin   // fold into the right half-plane
               base = (vz >= 0) ? PI_Q59 : -PI_Q59;
               vx = -vx;
               vz = -vz;
            end
            phi = base + cordic_vector(vx, vz);
            mag = vx;
         end
         rho = scale_round(mag, KINV_Q32, 32);
         theta = cordic_vector(rho, vy);
         rho = scale_round(rho, KINV_Q32, 32);
         lat = scale_round(theta, RAD2DEG_Q57, 94);
         if (lat > D90) lat = D90;
         if (lat < -D90) lat = -D90;
         r.lat = 30'(lat);
         r.lon = 31'(wrap_deg(D270 - scale_round(phi, RAD2DEG_Q57, 94)));
         len = (64'(rho) + 64'd2048) >> GUARD_SH;
         if (len > 64'(P_MAX)) len = 64'(P_MAX);
         r.len = len[46:0];
      end
      return r;
   endfunction

   initial begin
      logic [63:0] q, t;
      for (int i = 0; i < N_ITER; i++) begin
         q = 0;
         if (i == 0) begin
            q = PI_Q60;
         end else begin
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
               t = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
               q = k[0] ? q - t : q + t;
            end
         end
         atan_q59[i] = longint'((q + 64'd4) >> 3);
      end
   end

   // ---------------------------------------------------------------- directed table
   // Typed rows: sum of radius and altitude zero gives the origin; zero vector sets the flag.
   table_row_t dir_rows [0:17] = '{
      '{'{MODE_FWD, 0, 0, 0, 0, 0, 0}, 0, 0},
      '{'{MODE_FWD, D90, 0, 0, 0, 0, 0}, 0, 0},          // north pole
      '{'{MODE_FWD, -D90, 0, 0, 0, 0, 0}, 0, 0},         // south pole
      '{'{MODE_FWD, 0, -D180, 0, 0, 0, 0}, 0, 0},
      '{'{MODE_FWD, 0, LON_MAX, 0, 0, 0, 0}, 0, 0},
      '{'{MODE_FWD, 12345678, -3456789, P_MAX, 0, 0, 0}, 0, 0},
      '{'{MODE_FWD, -200000000, 500000000, P_MIN, 0, 0, 0}, 0, 0},
      '{'{MODE_FWD, 100, 200, -R_DEFAULT, 0, 0, 0}, 1, 0},
      '{'{MODE_FWD, D90, -D180, P_MAX, 0, 0, 0}, 0, 0},
      '{'{MODE_INV, 0, 0, 0, 0, 0, 0}, 1, 1},            // zero vector
      '{'{MODE_INV, 0, 0, 0, 0, 1000, 0}, 0, 0},         // on the polar axis
      '{'{MODE_INV, 0, 0, 0, 0, -P_MAX, 0}, 0, 0},
      '{'{MODE_INV, 0, 0, 0, -5000, 300, 7000}, 0, 0},
      '{'{MODE_INV, 0, 0, 0, -5000, 300, -7000}, 0, 0},
      '{'{MODE_INV, 0, 0, 0, P_MAX, P_MAX, P_MAX}, 0, 0}, // length saturates
      '{'{MODE_INV, 0, 0, 0, P_MIN, P_MIN, P_MIN}, 0, 0},
      '{'{MODE_INV, 0, 0, 0, 1, 0, 0}, 0, 0},
      '{'{MODE_INV, 0, 0, 0, 0, 0, -1}, 0, 0}
   };

   // ---------------------------------------------------------------- stimulus helpers
   function automatic longint rand_pos();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0, 1: return longint'($signed(w[47:0]));         // full range
         2:    return 0;
         default: return longint'($signed(w[37:0]));      // modest sizes
      endcase
   endfunction

   function automatic coord_item_t rand_item();
      coord_item_t it;
      it.mode = $urandom_range(0, 1);
      it.lat = longint'($urandom_range(0, 2 * 377487360)) - D90;
      it.lon = longint'($urandom_range(0, 32'd1509949439)) - D180;
      it.alt = rand_pos();
      it.x = rand_pos();
      it.y = rand_pos();
      it.z = rand_pos();
      return it;
   endfunction

   function automatic bit quiet_now();
      return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
   endfunction

   // present one item and hold it until accepted; predicts at the accepting edge
   task automatic send_item(input coord_item_t it, input bit typed, input bit zflag);
      coord_result_t exp_r;
      int gap;
      // each cycle idles with the same odds, so gaps come out geometric
      gap = 0;
      while (!quiet_now() && $urandom_range(0, 99) < 23) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_in_latitude <= 30'(it.lat);
      req_in_longitude <= 31'(it.lon);
      req_in_altitude <= 48'(it.alt);
      req_in_x <= 48'(it.x);
      req_in_y <= 48'(it.y);
      req_in_z <= 48'(it.z);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) begin
         exp_r = '{default: '0};
         exp_r.zero = zflag;
      end else begin
         exp_r = convert_item(it);
      end
      pending_results.push_back(exp_r);
   endtask

   // register write, only with the pipeline empty
   task automatic write_radius(input longint value);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= 47'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      radius_now = value & P_MAX;
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      longint radii [0:N_PHASES-1];
      radii[0] = R_DEFAULT;    // phase 0 runs on the reset value
      radii[1] = 0;
      radii[2] = P_MAX;
      radii[3] = longint'({$urandom, $urandom}) & P_MAX;
      radii[4] = R_DEFAULT;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            write_radius(radii[ph]);
         end
         if (ph == 0) begin
            foreach (dir_rows[i]) begin
               send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].zero_flag);
            end
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               // sender holds off until the pipeline has fully drained
               req_valid <= 1'b0;
               wait (pending_results.size() == 0);
               @(posedge clock);
            end
            send_item(rand_item(), 1'b0, 1'b0);
         end
      end
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("sphere_coord_cartesian_convert regression: pass");
      end else begin
         $display("sphere_coord_cartesian_convert regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side
   always @(posedge clock) begin
      coord_result_t exp_r;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_out_x !== exp_r.x) begin
                  $error("out_x: expected %0d, got %0d", exp_r.x, rsp_out_x);
                  fail_count++;
               end
               if (rsp_out_y !== exp_r.y) begin
                  $error("out_y: expected %0d, got %0d", exp_r.y, rsp_out_y);
                  fail_count++;
               end
               if (rsp_out_z !== exp_r.z) begin
                  $error("out_z: expected %0d, got %0d", exp_r.z, rsp_out_z);
                  fail_count++;
               end
               if (rsp_out_latitude !== exp_r.lat) begin
                  $error("out_latitude: expected %0d, got %0d", exp_r.lat, rsp_out_latitude);
                  fail_count++;
               end
               if (rsp_out_longitude !== exp_r.lon) begin
                  $error("out_longitude: expected %0d, got %0d", exp_r.lon, rsp_out_longitude);
                  fail_count++;
               end
               if (rsp_out_radial_length !== exp_r.len) begin
                  $error("out_radial_length: expected %0d, got %0d", exp_r.len,
                         rsp_out_radial_length);
                  fail_count++;
               end
               if (rsp_zero_vector !== exp_r.zero) begin
                  $error("zero_vector: expected %0d, got %0d", exp_r.zero, rsp_zero_vector);
                  fail_count++;
               end
            end
         end
         rsp_stall <= !quiet_now() && ($urandom_range(0, 99) < 23);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sphere_coord_cartesian_convert regression: fail");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
rtl/core/scc_pkg.sv
rtl/core/scc_delay.sv
rtl/core/scc_mulsh.sv
rtl/core/scc_cell.sv
rtl/core/scc_chain.sv
rtl/core/sphere_coord_cartesian_convert.sv
tb/sphere_coord_cartesian_convert_tb.sv
